// ===== sv/dfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dfc_pkg;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int OFF_W    = 11;
    localparam int LEN_W    = 11;
    localparam int STAT_W   = 3;
    localparam int CFG_W    = 12;
    localparam int CRC_W    = 32;
    localparam int HOLD_N   = 4;

    // line characters
    localparam logic [BYTE_W-1:0] CH_ESC  = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_FLAG = 8'h7E;
    localparam logic [BYTE_W-1:0] CH_BAD  = 8'h7F;
    localparam logic [BYTE_W-1:0] ESC_XOR = 8'h20;

    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [CFG_W-1:0] CFG_MAX_LEN_RST = 12'd2048;

    // depth of the front-to-back op queue
    localparam int QUEUE_DEPTH = 4;

    // frame status codes
    localparam logic [STAT_W-1:0] STAT_GOOD    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_SHORT   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_CRC     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FRAMING = 3'd3;
    localparam logic [STAT_W-1:0] STAT_OVERRUN = 3'd4;
    localparam logic [STAT_W-1:0] STAT_ABORTED = 3'd5;

    // output word kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // input command codes
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef enum logic [1:0] {
        FS_OUTSIDE = 2'd0,
        FS_BEGIN   = 2'd1,
        FS_INSIDE  = 2'd2,
        FS_ESCAPE  = 2'd3
    } t_fstate;

    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_DATA   = 2'd1,
        OP_STATUS = 2'd2,
        OP_CLOSE  = 2'd3
    } t_op_kind;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] out_byte;
        logic [OFF_W-1:0]  byte_offset;
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  frame_len;
        logic              last;
    } t_out_word;

    // one classified operation from front to back
    typedef struct packed {
        t_op_kind          kind;
        logic [BYTE_W-1:0] data;
        logic [OFF_W-1:0]  offset;
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  len;
        logic [CRC_W-1:0]  got;
    } t_op;

    // reflected CRC-32, one byte
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/dfc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfc_front #(
    parameter int MAX_FRAME = 2048
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire dfc_pkg::t_in_word          i_in,
    input  wire logic [dfc_pkg::CFG_W-1:0]  i_max_len,
    output dfc_pkg::t_op                    o_op,
    output logic                            o_op_valid
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int CMP_W = (CNT_W > dfc_pkg::CFG_W) ? CNT_W : dfc_pkg::CFG_W;
    localparam int EXT_W = (CNT_W > dfc_pkg::OFF_W) ? CNT_W : dfc_pkg::OFF_W;

    dfc_pkg::t_fstate r_state, n_state;
    logic             r_in_frame, n_in_frame;
    logic [CNT_W-1:0] r_count, n_count;
    logic [dfc_pkg::BYTE_W-1:0] r_hold [dfc_pkg::HOLD_N];
    logic [dfc_pkg::BYTE_W-1:0] n_hold [dfc_pkg::HOLD_N];

    // effective frame limit, clamped to MAX_FRAME
    logic [CMP_W-1:0] cfg_ext;
    logic [CMP_W-1:0] limit;
    logic [CMP_W-1:0] cnt_ext;
    logic [EXT_W-1:0] cnt_m4;
    logic             at_limit;
    logic             short_frame;
    logic             hold_filling;

    assign cfg_ext      = CMP_W'(i_max_len);
    assign limit        = (cfg_ext > CMP_W'(MAX_FRAME)) ? CMP_W'(MAX_FRAME) : cfg_ext;
    assign cnt_ext      = CMP_W'(r_count);
    assign at_limit     = (cnt_ext >= limit);
    assign cnt_m4       = EXT_W'(r_count) - EXT_W'(dfc_pkg::HOLD_N);
    assign short_frame  = (r_count <= CNT_W'(dfc_pkg::HOLD_N));
    // holdback not yet full: the byte is stored without a release
    assign hold_filling = (r_count < CNT_W'(dfc_pkg::HOLD_N));

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= dfc_pkg::FS_OUTSIDE;
            r_in_frame <= 1'b0;
            r_count    <= '0;
            for (int i = 0; i < dfc_pkg::HOLD_N; i++) begin
                r_hold[i] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            for (int i = 0; i < dfc_pkg::HOLD_N; i++) begin
                r_hold[i] <= n_hold[i];
            end
        end
    end

    // classify the accepted word
    always_comb begin
        logic                       do_data;
        logic                       do_store;
        logic                       do_close;
        logic                       do_abort;
        logic [dfc_pkg::BYTE_W-1:0] store_val;
        logic [dfc_pkg::STAT_W-1:0] abort_code;
        logic [dfc_pkg::BYTE_W-1:0] b;

        b          = i_in.rx_byte;
        do_data    = 1'b0;
        do_store   = 1'b0;
        do_close   = 1'b0;
        do_abort   = 1'b0;
        store_val  = b;
        abort_code = dfc_pkg::STAT_FRAMING;

        n_state    = r_state;
        n_in_frame = r_in_frame;
        n_count    = r_count;
        for (int i = 0; i < dfc_pkg::HOLD_N; i++) begin
            n_hold[i] = r_hold[i];
        end
        o_op_valid     = 1'b0;
        o_op.kind      = dfc_pkg::OP_STATUS;
        o_op.data      = '0;
        o_op.offset    = '0;
        o_op.status    = '0;
        o_op.len       = '0;
        o_op.got       = {r_hold[3], r_hold[2], r_hold[1], r_hold[0]};

        if (i_accept) begin
            if (i_in.command == dfc_pkg::CMD_RESTART) begin
                n_state    = dfc_pkg::FS_OUTSIDE;
                n_in_frame = 1'b0;
                if (r_in_frame) begin
                    o_op_valid  = 1'b1;
                    o_op.kind   = dfc_pkg::OP_STATUS;
                    o_op.status = dfc_pkg::STAT_ABORTED;
                end
            end else begin
                case (r_state)
                    dfc_pkg::FS_OUTSIDE: begin
                        if (b == dfc_pkg::CH_FLAG) begin
                            n_state = dfc_pkg::FS_BEGIN;
                            n_count = '0;
                            for (int i = 0; i < dfc_pkg::HOLD_N; i++) begin
                                n_hold[i] = '0;
                            end
                            o_op_valid = 1'b1;
                            o_op.kind  = dfc_pkg::OP_INIT;
                        end
                    end
                    dfc_pkg::FS_ESCAPE: begin
                        if (b == dfc_pkg::CH_FLAG) begin
                            do_abort = 1'b1;
                        end else begin
                            n_state   = dfc_pkg::FS_INSIDE;
                            do_store  = 1'b1;
                            store_val = b ^ dfc_pkg::ESC_XOR;
                        end
                    end
                    dfc_pkg::FS_BEGIN: begin
                        if (b != dfc_pkg::CH_FLAG) begin
                            n_state    = dfc_pkg::FS_INSIDE;
                            n_in_frame = 1'b1;
                            do_data    = 1'b1;
                        end
                    end
                    default: begin
                        do_data = 1'b1;
                    end
                endcase

                // plain data byte inside a frame
                if (do_data) begin
                    if (b == dfc_pkg::CH_ESC) begin
                        n_state = dfc_pkg::FS_ESCAPE;
                    end else if (b == dfc_pkg::CH_BAD) begin
                        do_abort = 1'b1;
                    end else if (b == dfc_pkg::CH_FLAG) begin
                        do_close = 1'b1;
                    end else begin
                        do_store = 1'b1;
                    end
                end

                // store into the holdback, releasing the oldest byte once the holdback is full
                if (do_store) begin
                    if (at_limit) begin
                        do_abort   = 1'b1;
                        abort_code = dfc_pkg::STAT_OVERRUN;
                    end else if (hold_filling) begin
                        n_hold[r_count[1:0]] = store_val;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_hold[0]   = r_hold[1];
                        n_hold[1]   = r_hold[2];
                        n_hold[2]   = r_hold[3];
                        n_hold[3]   = store_val;
                        n_count     = r_count + CNT_W'(1);
                        o_op_valid  = 1'b1;
                        o_op.kind   = dfc_pkg::OP_DATA;
                        o_op.data   = r_hold[0];
                        o_op.offset = cnt_m4[dfc_pkg::OFF_W-1:0];
                    end
                end

                // closing flag: short check here, CRC check in the back end
                if (do_close) begin
                    n_state    = dfc_pkg::FS_OUTSIDE;
                    n_in_frame = 1'b0;
                    o_op_valid = 1'b1;
                    if (short_frame) begin
                        o_op.kind   = dfc_pkg::OP_STATUS;
                        o_op.status = dfc_pkg::STAT_SHORT;
                    end else begin
                        o_op.kind = dfc_pkg::OP_CLOSE;
                        o_op.len  = cnt_m4[dfc_pkg::LEN_W-1:0];
                    end
                end

                if (do_abort) begin
                    n_state     = dfc_pkg::FS_OUTSIDE;
                    n_in_frame  = 1'b0;
                    o_op_valid  = 1'b1;
                    o_op.kind   = dfc_pkg::OP_STATUS;
                    o_op.status = abort_code;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/dfc_op_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfc_op_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire dfc_pkg::t_op  i_op,
    output logic               o_full,
    input  wire logic          i_pop,
    output dfc_pkg::t_op       o_head,
    output logic               o_empty
);

    localparam int DEPTH = dfc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    dfc_pkg::t_op     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/dfc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire dfc_pkg::t_op   i_op,
    input  wire logic           i_op_empty,
    output logic                o_op_pop,
    output dfc_pkg::t_out_word  o_out,
    output logic                o_empty,
    input  wire logic           i_pop
);

    logic [dfc_pkg::CRC_W-1:0] r_crc, n_crc;
    dfc_pkg::t_out_word        r_out, n_out;
    logic                      r_out_valid;
    logic                      n_word;
    logic                      take;

    // take an op when the output slot is free or being drained
    assign take     = !i_op_empty && (!r_out_valid || i_pop);
    assign o_op_pop = take;
    assign o_out    = r_out;
    assign o_empty  = !r_out_valid;

    // carry out the op
    always_comb begin
        n_crc             = r_crc;
        n_word            = 1'b0;
        n_out.kind        = dfc_pkg::KIND_STATUS;
        n_out.out_byte    = '0;
        n_out.byte_offset = '0;
        n_out.status      = '0;
        n_out.frame_len   = '0;
        n_out.last        = 1'b1;
        case (i_op.kind)
            dfc_pkg::OP_INIT: begin
                n_crc = dfc_pkg::CRC_INIT;
            end
            dfc_pkg::OP_DATA: begin
                n_crc             = dfc_pkg::crc_byte(r_crc, i_op.data);
                n_word            = 1'b1;
                n_out.kind        = dfc_pkg::KIND_PAYLOAD;
                n_out.out_byte    = i_op.data;
                n_out.byte_offset = i_op.offset;
                n_out.last        = 1'b0;
            end
            dfc_pkg::OP_CLOSE: begin
                n_word = 1'b1;
                if (~r_crc != i_op.got) begin
                    n_out.status = dfc_pkg::STAT_CRC;
                end else begin
                    n_out.status    = dfc_pkg::STAT_GOOD;
                    n_out.frame_len = i_op.len;
                end
            end
            default: begin
                n_word       = 1'b1;
                n_out.status = i_op.status;
            end
        endcase
    end

    // CRC and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= dfc_pkg::CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_crc       <= n_crc;
                r_out_valid <= n_word;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (take && n_word) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ===== sv/fir_deframer_crc32_check_unit.sv =====
// Each result word is registered first in the op queue, then in the output word register.
// One input word per cycle while not full; one CRC-32 byte step per cycle in the back end.
// The front classifies words into a four-entry op queue; the back drains one op a cycle,
// so full rises only once four ops wait behind an unread output word.
// Reset (synchronous, active low): outside frame, empty queues, CRC all ones,
// frame limit 2048.
`timescale 1ns / 1ps
`default_nettype none

module fir_deframer_crc32_check_unit #(
    parameter int MAX_FRAME = 2048
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    output logic                            o_full,
    input  wire dfc_pkg::t_in_word          i_in,
    output logic                            o_empty,
    input  wire logic                       i_pop,
    output dfc_pkg::t_out_word              o_out,
    input  wire logic                       i_cfg_we,
    input  wire logic [dfc_pkg::CFG_W-1:0]  i_cfg_data
);

    logic [dfc_pkg::CFG_W-1:0] r_max_len;
    logic                      accept;
    dfc_pkg::t_op              front_op;
    logic                      front_op_valid;
    dfc_pkg::t_op              head_op;
    logic                      q_empty;
    logic                      q_pop;

    // frame length limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= dfc_pkg::CFG_MAX_LEN_RST;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    assign accept = i_push && !o_full;

    dfc_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in       (i_in),
        .i_max_len  (r_max_len),
        .o_op       (front_op),
        .o_op_valid (front_op_valid)
    );

    dfc_op_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_op_valid),
        .i_op    (front_op),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_head  (head_op),
        .o_empty (q_empty)
    );

    dfc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (head_op),
        .i_op_empty (q_empty),
        .o_op_pop   (q_pop),
        .o_out      (o_out),
        .o_empty    (o_empty),
        .i_pop      (i_pop)
    );

    // a status word always closes the run, a payload word never does
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_out.last == o_out.kind))
        else $error("last does not match kind");

    // payload words carry no status or length
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_out.kind == dfc_pkg::KIND_PAYLOAD)) |->
        ((o_out.status == dfc_pkg::STAT_GOOD) && (o_out.frame_len == '0)))
        else $error("payload word with status fields");

    // only a good status carries a frame length
    a_len_good_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_out.kind == dfc_pkg::KIND_STATUS) &&
         (o_out.status != dfc_pkg::STAT_GOOD)) |-> (o_out.frame_len == '0))
        else $error("frame length on a failed frame");

    // queue cannot be full right after reset
    a_reset_not_full: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (!o_full && o_empty))
        else $error("queues not empty after reset");

endmodule

`default_nettype wire
